// ===== rtl/core/quad_motor_mixer_defines.svh =====
// Assertion macros shared by the quad motor mixer RTL.
`ifndef QUAD_MOTOR_MIXER_DEFINES_SVH
`define QUAD_MOTOR_MIXER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on clk, disabled while arst_n is low.
`define QMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included.
`define QMM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QMM_ASSERT(label, prop, msg)
`define QMM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/qmm_pkg.sv =====
// Types, constants and arithmetic helpers of the quad motor mixer.
package qmm_pkg;

	localparam int MOTOR_COUNT = 4;
	localparam int MOTOR_W     = $clog2(MOTOR_COUNT);
	localparam int PULSE_W     = 11;
	localparam int TERM_W      = 16;
	localparam int MIX_W       = TERM_W + 2;
	localparam int RND_W       = MIX_W - 4;
	localparam int VAL_W       = 16;
	localparam int CFG_IDX_W   = 3;

	localparam logic [MOTOR_W-1:0] LAST_MOTOR = MOTOR_W'(MOTOR_COUNT - 1);

	localparam logic signed [VAL_W:0] PULSE_MIN = 17'sd1000;
	localparam logic signed [VAL_W:0] PULSE_MAX = 17'sd2000;

	localparam logic [PULSE_W-1:0] DISARMED_RESET    = 11'd1000;
	localparam logic [PULSE_W-1:0] FAILSAFE_RESET    = 11'd1000;
	localparam logic [PULSE_W-1:0] LOOP_ENABLE_RESET = 11'd1050;

	// Sign of each term per motor, bit m set means the term is subtracted.
	localparam logic [MOTOR_COUNT-1:0] MIX_PITCH_NEG = 4'b1010;
	localparam logic [MOTOR_COUNT-1:0] MIX_ROLL_NEG  = 4'b0011;
	localparam logic [MOTOR_COUNT-1:0] MIX_YAW_NEG   = 4'b0110;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISARMED_0   = 3'd0,
		REG_DISARMED_1   = 3'd1,
		REG_DISARMED_2   = 3'd2,
		REG_DISARMED_3   = 3'd3,
		REG_FAILSAFE     = 3'd4,
		REG_LOOP_ENABLE  = 3'd5
	} qmm_reg_t;

	typedef logic [PULSE_W-1:0] pulse_t;
	typedef logic signed [VAL_W-1:0] mval_t;

	typedef struct packed {
		pulse_t [MOTOR_COUNT-1:0] disarmed_value;
		pulse_t                   failsafe_speed;
		pulse_t                   loop_enable_throttle;
	} qmm_cfg_t;

	typedef struct packed {
		logic [PULSE_W-1:0] throttle;
		logic               armed;
		logic               failsafe_active;
		logic               angle_mode;
		logic [TERM_W-1:0]  pitch_angle_term;
		logic [TERM_W-1:0]  roll_angle_term;
		logic [TERM_W-1:0]  pitch_rate_term;
		logic [TERM_W-1:0]  roll_rate_term;
		logic [TERM_W-1:0]  yaw_rate_term;
	} qmm_item_t;

	typedef struct packed {
		logic armed;
		logic failsafe_active;
	} qmm_flags_t;

	// Q.4 to integer, round to nearest, ties to even.
	function automatic logic signed [RND_W-1:0] round_q4(input logic signed [MIX_W-1:0] s);
		logic signed [RND_W-1:0] q;
		logic [3:0]              frac;
		logic                    up;
		q    = s[MIX_W-1:4];
		frac = s[3:0];
		up   = (frac > 4'd8) || ((frac == 4'd8) && q[0]);
		return q + $signed({{(RND_W-1){1'b0}}, up});
	endfunction

	function automatic pulse_t clamp_pulse(input logic signed [VAL_W:0] v);
		logic signed [VAL_W:0] c;
		if (v < PULSE_MIN) begin
			c = PULSE_MIN;
		end else if (v > PULSE_MAX) begin
			c = PULSE_MAX;
		end else begin
			c = v;
		end
		return c[PULSE_W-1:0];
	endfunction

endpackage

// ===== rtl/core/qmm_regs.sv =====
// Configuration registers of the quad motor mixer.
module qmm_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [qmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qmm_pkg::PULSE_W-1:0]     cfg_data,
	output qmm_pkg::qmm_cfg_t               cfg
);

	qmm_pkg::qmm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qmm_pkg::MOTOR_COUNT; i++) begin
				cfg_q.disarmed_value[i] <= qmm_pkg::DISARMED_RESET;
			end
			cfg_q.failsafe_speed       <= qmm_pkg::FAILSAFE_RESET;
			cfg_q.loop_enable_throttle <= qmm_pkg::LOOP_ENABLE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				qmm_pkg::REG_DISARMED_0:  cfg_q.disarmed_value[0]   <= cfg_data;
				qmm_pkg::REG_DISARMED_1:  cfg_q.disarmed_value[1]   <= cfg_data;
				qmm_pkg::REG_DISARMED_2:  cfg_q.disarmed_value[2]   <= cfg_data;
				qmm_pkg::REG_DISARMED_3:  cfg_q.disarmed_value[3]   <= cfg_data;
				qmm_pkg::REG_FAILSAFE:    cfg_q.failsafe_speed       <= cfg_data;
				qmm_pkg::REG_LOOP_ENABLE: cfg_q.loop_enable_throttle <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/qmm_mix.sv =====
// Input register and per-motor mixing stage of the quad motor mixer.
`include "quad_motor_mixer_defines.svh"

module qmm_mix (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  qmm_pkg::qmm_item_t            item,
	input  logic [qmm_pkg::PULSE_W-1:0]   loop_enable_throttle,
	output logic                          s2_valid,
	input  logic                          ser_ready,
	output qmm_pkg::mval_t                val_s2 [qmm_pkg::MOTOR_COUNT],
	output qmm_pkg::qmm_flags_t           flags_s2
);

	qmm_pkg::qmm_item_t  item_s1;
	logic                s1_valid;
	logic                s1_ready;
	logic                s2_ready;
	logic                s2_valid_q;
	logic                loop_en;
	logic signed [qmm_pkg::MIX_W-1:0] pitch;
	logic signed [qmm_pkg::MIX_W-1:0] roll;
	logic signed [qmm_pkg::MIX_W-1:0] yaw;
	logic signed [qmm_pkg::MIX_W-1:0] pr_sum [qmm_pkg::MOTOR_COUNT];
	logic signed [qmm_pkg::MIX_W-1:0] yaw_m  [qmm_pkg::MOTOR_COUNT];
	logic signed [qmm_pkg::RND_W-1:0] pr_rnd [qmm_pkg::MOTOR_COUNT];
	logic signed [qmm_pkg::RND_W-1:0] yaw_rnd[qmm_pkg::MOTOR_COUNT];
	qmm_pkg::mval_t      val    [qmm_pkg::MOTOR_COUNT];

	assign s2_ready = !s2_valid_q || ser_ready;
	assign s1_ready = !s1_valid || s2_ready;
	assign in_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid <= in_valid;
			end
			if (s2_ready) begin
				s2_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			item_s1 <= item;
		end
		if (s1_valid && s2_ready) begin
			val_s2                   <= val;
			flags_s2.armed           <= item_s1.armed;
			flags_s2.failsafe_active <= item_s1.failsafe_active;
		end
	end

	always_comb begin
		loop_en = item_s1.throttle > loop_enable_throttle;
		if (item_s1.angle_mode) begin
			pitch = qmm_pkg::MIX_W'($signed(item_s1.pitch_angle_term));
			roll  = qmm_pkg::MIX_W'($signed(item_s1.roll_angle_term));
		end else begin
			pitch = qmm_pkg::MIX_W'($signed(item_s1.pitch_rate_term));
			roll  = qmm_pkg::MIX_W'($signed(item_s1.roll_rate_term));
		end
		yaw = qmm_pkg::MIX_W'($signed(item_s1.yaw_rate_term));
		for (int m = 0; m < qmm_pkg::MOTOR_COUNT; m++) begin
			pr_sum[m] = (qmm_pkg::MIX_PITCH_NEG[m] ? -pitch : pitch)
				+ (qmm_pkg::MIX_ROLL_NEG[m] ? -roll : roll);
			yaw_m[m]   = qmm_pkg::MIX_YAW_NEG[m] ? -yaw : yaw;
			pr_rnd[m]  = qmm_pkg::round_q4(pr_sum[m]);
			yaw_rnd[m] = qmm_pkg::round_q4(yaw_m[m]);
			val[m] = $signed({{(qmm_pkg::VAL_W-qmm_pkg::PULSE_W){1'b0}}, item_s1.throttle});
			if (loop_en) begin
				val[m] = val[m] + qmm_pkg::VAL_W'(pr_rnd[m]) + qmm_pkg::VAL_W'(yaw_rnd[m]);
			end
		end
	end

	assign s2_valid = s2_valid_q;

	`QMM_ASSERT(a_s1_moves_to_s2, (s1_valid && s2_ready) |=> s2_valid_q, "mix stage lost a transaction")
	`QMM_ASSERT(a_s2_holds, (s2_valid_q && !ser_ready) |=> s2_valid_q, "mix stage dropped a stalled transaction")
	`QMM_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid, "input stalled with empty input register")

endmodule

// ===== rtl/core/qmm_headroom.sv =====
// Headroom limiting, mode selection and clamping of the four motor values.
module qmm_headroom (
	input  qmm_pkg::mval_t       val   [qmm_pkg::MOTOR_COUNT],
	input  qmm_pkg::qmm_flags_t  flags,
	input  qmm_pkg::qmm_cfg_t    cfg,
	output qmm_pkg::pulse_t      pulse [qmm_pkg::MOTOR_COUNT]
);

	qmm_pkg::mval_t max01;
	qmm_pkg::mval_t max23;
	qmm_pkg::mval_t max_all;
	qmm_pkg::mval_t excess;
	logic           over;
	qmm_pkg::mval_t adj [qmm_pkg::MOTOR_COUNT];

	always_comb begin
		max01   = (val[0] > val[1]) ? val[0] : val[1];
		max23   = (val[2] > val[3]) ? val[2] : val[3];
		max_all = (max01 > max23) ? max01 : max23;
		if (max_all < 0) begin
			max_all = '0;
		end
		over   = $signed({max_all[qmm_pkg::VAL_W-1], max_all}) > qmm_pkg::PULSE_MAX;
		excess = max_all - qmm_pkg::VAL_W'(qmm_pkg::PULSE_MAX);
		for (int m = 0; m < qmm_pkg::MOTOR_COUNT; m++) begin
			adj[m] = over ? (val[m] - excess) : val[m];
			priority if (flags.failsafe_active) begin
				pulse[m] = qmm_pkg::clamp_pulse($signed({6'b0, cfg.failsafe_speed}));
			end else if (flags.armed) begin
				pulse[m] = qmm_pkg::clamp_pulse($signed({adj[m][qmm_pkg::VAL_W-1], adj[m]}));
			end else begin
				pulse[m] = qmm_pkg::clamp_pulse($signed({6'b0, cfg.disarmed_value[m]}));
			end
		end
	end

endmodule

// ===== rtl/core/qmm_serializer.sv =====
// Result register that emits the four motor pulses one transaction per cycle while out_stall is low.
`include "quad_motor_mixer_defines.svh"

module qmm_serializer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s2_valid,
	output logic                          ser_ready,
	input  qmm_pkg::pulse_t               pulse [qmm_pkg::MOTOR_COUNT],
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [qmm_pkg::MOTOR_W-1:0]   motor_number,
	output logic [qmm_pkg::PULSE_W-1:0]   motor_pulse,
	output logic                          last_motor
);

	qmm_pkg::pulse_t              bundle_q [qmm_pkg::MOTOR_COUNT];
	logic [qmm_pkg::MOTOR_W-1:0]  idx_q;
	logic                         busy_q;
	logic                         out_fire;
	logic                         is_last;
	logic                         load;

	assign is_last   = idx_q == qmm_pkg::LAST_MOTOR;
	assign out_fire  = busy_q && !out_stall;
	assign ser_ready = !busy_q || (out_fire && is_last);
	assign load      = s2_valid && ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= pulse;
		end
	end

	assign out_valid    = busy_q;
	assign motor_number = idx_q;
	assign motor_pulse  = bundle_q[idx_q];
	assign last_motor   = is_last;

	`QMM_ASSERT(a_pulse_range, busy_q |-> ((motor_pulse >= 11'd1000) && (motor_pulse <= 11'd2000)), "motor pulse out of range")
	`QMM_ASSERT(a_next_motor, (out_fire && !is_last) |=> (busy_q && (idx_q == $past(idx_q) + 1'b1)), "motor sequence broken")

endmodule

// ===== rtl/core/quad_motor_mixer.sv =====
// Top level of the quad motor mixer.
// Each accepted control update yields four motor transactions, motor 0 to 3 in
// order, one per cycle while out_stall is low, last_motor marking motor 3. The
// first motor passes the input register, mix stage and result register before
// it can be taken. The result register takes a new update as motor 3 is taken;
// the input and mix stages keep taking updates while results wait, so up to
// three updates are in flight. Configuration writes take effect at the next
// edge and should be made while no update is in flight.
module quad_motor_mixer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [qmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qmm_pkg::PULSE_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [10:0]                   throttle,
	input  logic                          armed,
	input  logic                          failsafe_active,
	input  logic                          angle_mode,
	input  logic signed [15:0]            pitch_angle_term,
	input  logic signed [15:0]            roll_angle_term,
	input  logic signed [15:0]            pitch_rate_term,
	input  logic signed [15:0]            roll_rate_term,
	input  logic signed [15:0]            yaw_rate_term,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    motor_number,
	output logic [10:0]                   motor_pulse,
	output logic                          last_motor
);

	qmm_pkg::qmm_cfg_t   cfg;
	qmm_pkg::qmm_item_t  item;
	qmm_pkg::qmm_flags_t flags_s2;
	qmm_pkg::mval_t      val_s2 [qmm_pkg::MOTOR_COUNT];
	qmm_pkg::pulse_t     pulse  [qmm_pkg::MOTOR_COUNT];
	logic                s2_valid;
	logic                ser_ready;

	always_comb begin
		item.throttle         = throttle;
		item.armed            = armed;
		item.failsafe_active  = failsafe_active;
		item.angle_mode       = angle_mode;
		item.pitch_angle_term = pitch_angle_term;
		item.roll_angle_term  = roll_angle_term;
		item.pitch_rate_term  = pitch_rate_term;
		item.roll_rate_term   = roll_rate_term;
		item.yaw_rate_term    = yaw_rate_term;
	end

	qmm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qmm_mix u_mix (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.item                 (item),
		.loop_enable_throttle (cfg.loop_enable_throttle),
		.s2_valid             (s2_valid),
		.ser_ready            (ser_ready),
		.val_s2               (val_s2),
		.flags_s2             (flags_s2)
	);

	qmm_headroom u_headroom (
		.val   (val_s2),
		.flags (flags_s2),
		.cfg   (cfg),
		.pulse (pulse)
	);

	qmm_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.s2_valid     (s2_valid),
		.ser_ready    (ser_ready),
		.pulse        (pulse),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.motor_number (motor_number),
		.motor_pulse  (motor_pulse),
		.last_motor   (last_motor)
	);

endmodule

// ===== tb/quad_motor_mixer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the quad motor mixer: directed and random control updates.
module quad_motor_mixer_test;

	// Bit m set: the term is subtracted for motor m.
	localparam logic [3:0] PITCH_SUB = 4'b1010;
	localparam logic [3:0] ROLL_SUB  = 4'b0011;
	localparam logic [3:0] YAW_SUB   = 4'b0110;

	typedef struct {
		logic [1:0]       motor;
		qmm_pkg::pulse_t  pulse;
		logic             last;
	} motor_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_write = 1'b0;
	logic [qmm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [qmm_pkg::PULSE_W-1:0]   cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [10:0]                   throttle = '0;
	logic                          armed = 1'b0;
	logic                          failsafe_active = 1'b0;
	logic                          angle_mode = 1'b0;
	logic signed [15:0]            pitch_angle_term = '0;
	logic signed [15:0]            roll_angle_term = '0;
	logic signed [15:0]            pitch_rate_term = '0;
	logic signed [15:0]            roll_rate_term = '0;
	logic signed [15:0]            yaw_rate_term = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    motor_number;
	logic [10:0]                   motor_pulse;
	logic                          last_motor;

	qmm_pkg::qmm_cfg_t mixer_cfg;
	motor_result_t     expected_motors[$];
	int                errors = 0;
	bit                quiet = 1'b0;
	bit                hold_request = 1'b0;

	quad_motor_mixer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.throttle         (throttle),
		.armed            (armed),
		.failsafe_active  (failsafe_active),
		.angle_mode       (angle_mode),
		.pitch_angle_term (pitch_angle_term),
		.roll_angle_term  (roll_angle_term),
		.pitch_rate_term  (pitch_rate_term),
		.roll_rate_term   (roll_rate_term),
		.yaw_rate_term    (yaw_rate_term),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.motor_number     (motor_number),
		.motor_pulse      (motor_pulse),
		.last_motor       (last_motor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Q.4 to integer, nearest, ties to even.
	function automatic int round_half_even(int s);
		int q;
		q = s >>> 4;
		if ((s & 15) > 8 || ((s & 15) == 8 && q[0])) begin
			q++;
		end
		return q;
	endfunction

	function automatic qmm_pkg::pulse_t clamp_width(int v);
		if (v < int'(qmm_pkg::PULSE_MIN)) begin
			return qmm_pkg::pulse_t'(qmm_pkg::PULSE_MIN);
		end
		if (v > int'(qmm_pkg::PULSE_MAX)) begin
			return qmm_pkg::pulse_t'(qmm_pkg::PULSE_MAX);
		end
		return qmm_pkg::pulse_t'(v);
	endfunction

	function automatic void predict_motors(qmm_pkg::qmm_item_t u);
		int            pitch, roll, yaw, peak, v;
		int            mixed[qmm_pkg::MOTOR_COUNT];
		motor_result_t r;
		pitch = u.angle_mode ? int'($signed(u.pitch_angle_term))
			: int'($signed(u.pitch_rate_term));
		roll  = u.angle_mode ? int'($signed(u.roll_angle_term))
			: int'($signed(u.roll_rate_term));
		yaw   = int'($signed(u.yaw_rate_term));
		peak  = 0;
		for (int m = 0; m < qmm_pkg::MOTOR_COUNT; m++) begin
			v = int'(u.throttle);
			if (u.throttle > mixer_cfg.loop_enable_throttle) begin
				v += round_half_even((PITCH_SUB[m] ? -pitch : pitch) +
					(ROLL_SUB[m] ? -roll : roll));
				v += round_half_even(YAW_SUB[m] ? -yaw : yaw);
			end
			mixed[m] = v;
			if (v > peak) begin
				peak = v;
			end
		end
		for (int m = 0; m < qmm_pkg::MOTOR_COUNT; m++) begin
			r.motor = m[1:0];
			r.last  = (m == qmm_pkg::MOTOR_COUNT - 1);
			if (u.failsafe_active) begin
				r.pulse = clamp_width(int'(mixer_cfg.failsafe_speed));
			end else if (u.armed) begin
				r.pulse = clamp_width(peak > int'(qmm_pkg::PULSE_MAX)
					? mixed[m] - (peak - int'(qmm_pkg::PULSE_MAX)) : mixed[m]);
			end else begin
				r.pulse = clamp_width(int'(mixer_cfg.disarmed_value[m]));
			end
			expected_motors.push_back(r);
		end
	endfunction

	function automatic qmm_pkg::qmm_item_t make_update(int thr, int arm, int fs, int angle,
			int pa, int ra, int pr, int rr, int yw);
		qmm_pkg::qmm_item_t u;
		u.throttle         = 11'(thr);
		u.armed            = 1'(arm);
		u.failsafe_active  = 1'(fs);
		u.angle_mode       = 1'(angle);
		u.pitch_angle_term = 16'(pa);
		u.roll_angle_term  = 16'(ra);
		u.pitch_rate_term  = 16'(pr);
		u.roll_rate_term   = 16'(rr);
		u.yaw_rate_term    = 16'(yw);
		return u;
	endfunction

	// Shaped: armed flight with throttle from 1060 to 1950 and moderate terms.
	function automatic qmm_pkg::qmm_item_t random_update(bit shaped);
		qmm_pkg::qmm_item_t u;
		u.throttle         = 11'($urandom_range(2047));
		u.armed            = 1'($urandom_range(1));
		u.failsafe_active  = 1'($urandom_range(1));
		u.angle_mode       = 1'($urandom_range(1));
		u.pitch_angle_term = 16'($urandom);
		u.roll_angle_term  = 16'($urandom);
		u.pitch_rate_term  = 16'($urandom);
		u.roll_rate_term   = 16'($urandom);
		u.yaw_rate_term    = 16'($urandom);
		if (shaped) begin
			u.armed            = 1'b1;
			u.failsafe_active  = ($urandom_range(19) == 0);
			u.throttle         = 11'($urandom_range(1950, 1060));
			u.pitch_angle_term = 16'($urandom_range(6400) - 3200);
			u.roll_angle_term  = 16'($urandom_range(6400) - 3200);
			u.pitch_rate_term  = 16'($urandom_range(6400) - 3200);
			u.roll_rate_term   = 16'($urandom_range(6400) - 3200);
			u.yaw_rate_term    = 16'($urandom_range(3200) - 1600);
		end
		return u;
	endfunction

	task automatic send_update(input qmm_pkg::qmm_item_t u);
		while (!quiet && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		throttle         <= u.throttle;
		armed            <= u.armed;
		failsafe_active  <= u.failsafe_active;
		angle_mode       <= u.angle_mode;
		pitch_angle_term <= u.pitch_angle_term;
		roll_angle_term  <= u.roll_angle_term;
		pitch_rate_term  <= u.pitch_rate_term;
		roll_rate_term   <= u.roll_rate_term;
		yaw_rate_term    <= u.yaw_rate_term;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_motors(u);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_motors.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input qmm_pkg::qmm_reg_t idx, input qmm_pkg::pulse_t value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		case (idx)
			qmm_pkg::REG_DISARMED_0: begin
				mixer_cfg.disarmed_value[0] = value;
			end
			qmm_pkg::REG_DISARMED_1: begin
				mixer_cfg.disarmed_value[1] = value;
			end
			qmm_pkg::REG_DISARMED_2: begin
				mixer_cfg.disarmed_value[2] = value;
			end
			qmm_pkg::REG_DISARMED_3: begin
				mixer_cfg.disarmed_value[3] = value;
			end
			qmm_pkg::REG_FAILSAFE: begin
				mixer_cfg.failsafe_speed = value;
			end
			qmm_pkg::REG_LOOP_ENABLE: begin
				mixer_cfg.loop_enable_throttle = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(input int d0, input int d1, input int d2, input int d3,
			input int fs, input int loop_thr);
		settle();
		write_reg(qmm_pkg::REG_DISARMED_0, qmm_pkg::pulse_t'(d0));
		write_reg(qmm_pkg::REG_DISARMED_1, qmm_pkg::pulse_t'(d1));
		write_reg(qmm_pkg::REG_DISARMED_2, qmm_pkg::pulse_t'(d2));
		write_reg(qmm_pkg::REG_DISARMED_3, qmm_pkg::pulse_t'(d3));
		write_reg(qmm_pkg::REG_FAILSAFE, qmm_pkg::pulse_t'(fs));
		write_reg(qmm_pkg::REG_LOOP_ENABLE, qmm_pkg::pulse_t'(loop_thr));
		cfg_write <= 1'b0;
	endtask

	task automatic test_power_up_defaults();
		send_update(make_update(1500, 0, 0, 1, 800, -800, 0, 0, 160));
		send_update(make_update(1500, 0, 1, 1, 800, -800, 0, 0, 160));
		send_update(make_update(1050, 1, 0, 1, 32767, -32768, 0, 0, 32767));
		send_update(make_update(1051, 1, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_flag_priority();
		apply_settings(1111, 1222, 1333, 1444, 1777, 1050);
		send_update(make_update(1600, 0, 0, 1, 480, 320, 0, 0, 96));
		send_update(make_update(1600, 0, 1, 1, 480, 320, 0, 0, 96));
		send_update(make_update(1600, 1, 1, 1, 480, 320, 0, 0, 96));
		send_update(make_update(1600, 1, 0, 1, 480, 320, 0, 0, 96));
	endtask

	task automatic test_rounding_ties();
		send_update(make_update(1500, 1, 0, 1, 8, 0, 0, 0, 0));
		send_update(make_update(1500, 1, 0, 1, 24, 0, 0, 0, 0));
		send_update(make_update(1500, 1, 0, 1, 0, 40, 0, 0, 0));
		send_update(make_update(1500, 1, 0, 1, 8, 8, 0, 0, 8));
		send_update(make_update(1500, 1, 0, 1, 7, -9, 0, 0, -24));
	endtask

	task automatic test_mode_select();
		send_update(make_update(1400, 1, 0, 1, 1600, -480, -3200, 960, 0));
		send_update(make_update(1400, 1, 0, 0, 1600, -480, -3200, 960, 0));
	endtask

	task automatic test_field_extremes();
		send_update(make_update(0, 1, 0, 1, 32767, 32767, 0, 0, 32767));
		send_update(make_update(2047, 1, 0, 0, 0, 0, 0, 0, 0));
		send_update(make_update(2047, 1, 0, 1, 32767, 32767, 32767, 32767, 32767));
		send_update(make_update(1500, 1, 0, 1, -32768, -32768, 0, 0, -32768));
		send_update(make_update(1500, 1, 0, 0, 0, 0, 32767, -32768, -32768));
		send_update(make_update(1100, 1, 0, 0, 0, 0, -32768, -32768, 0));
		send_update(make_update(1900, 1, 0, 1, 3200, 0, 0, 0, 0));
	endtask

	// Receiver holds off while updates keep coming, so the input side must stall.
	task automatic test_back_pressure();
		settle();
		hold_request = 1'b1;
		repeat (12) send_update(random_update(1'b1));
	endtask

	task automatic test_config_extremes();
		apply_settings(0, 0, 0, 0, 0, 0);
		repeat (8) send_update(random_update(1'($urandom_range(1))));
		apply_settings(2047, 2047, 2047, 2047, 2047, 2047);
		repeat (8) send_update(random_update(1'($urandom_range(1))));
		apply_settings(1000, 2000, 999, 2001, 2000, 1000);
		repeat (8) send_update(random_update(1'($urandom_range(1))));
		repeat (2) begin
			apply_settings($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
				$urandom_range(2047), $urandom_range(2047), $urandom_range(2047));
			repeat (8) send_update(random_update(1'($urandom_range(1))));
		end
	endtask

	task automatic test_random_traffic();
		apply_settings(1010, 1020, 1030, 1040, 1500, 1050);
		quiet = 1'b1;
		for (int i = 0; i < 90; i++) begin
			if (i == 30) begin
				quiet = 1'b0;
			end
			send_update(random_update($urandom_range(99) < 80));
		end
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 17);
			end
		end
	end

	always @(posedge clk) begin : motor_check
		motor_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_motors.size() == 0) begin
				$error("unexpected motor transaction: motor_number %0d motor_pulse %0d",
					motor_number, motor_pulse);
				errors++;
			end else begin
				want = expected_motors.pop_front();
				if (motor_number !== want.motor) begin
					$error("motor_number: expected %0d, actual %0d", want.motor, motor_number);
					errors++;
				end
				if (motor_pulse !== want.pulse) begin
					$error("motor_pulse: expected %0d, actual %0d", want.pulse, motor_pulse);
					errors++;
				end
				if (last_motor !== want.last) begin
					$error("last_motor: expected %0d, actual %0d", want.last, last_motor);
					errors++;
				end
			end
		end
	end

	initial begin
		mixer_cfg.disarmed_value       = {qmm_pkg::MOTOR_COUNT{qmm_pkg::DISARMED_RESET}};
		mixer_cfg.failsafe_speed       = qmm_pkg::FAILSAFE_RESET;
		mixer_cfg.loop_enable_throttle = qmm_pkg::LOOP_ENABLE_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_power_up_defaults();
		test_flag_priority();
		test_rounding_ties();
		test_mode_select();
		test_field_extremes();
		test_back_pressure();
		test_config_extremes();
		test_random_traffic();
		settle();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/qmm_pkg.sv
rtl/core/qmm_regs.sv
rtl/core/qmm_mix.sv
rtl/core/qmm_headroom.sv
rtl/core/qmm_serializer.sv
rtl/core/quad_motor_mixer.sv
tb/quad_motor_mixer_test.sv
